[design/hgpc_pkg.sv]
package hgpc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SQRT3_FIX  = 113512;
  localparam int SQRT_BITS  = 18;
  localparam int QUO_BITS   = 16;
  localparam int NUM_BITS   = 35;
  localparam int DV_BITS    = 14;
  localparam int SIZE_BITS  = 12;
  localparam int DIV_STAGES = QUO_BITS;
  localparam int REM_BITS   = 31;
  localparam int ERR_BITS   = 31;
  localparam int K_BITS     = 17;
  localparam int AX_BITS    = 19;
  localparam int OFS_BITS   = 20;
  localparam int CMP_BITS   = 48;

  localparam logic signed [31:0] COORD_MAX = 32'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [31:0] COORD_MIN = -COORD_MAX - 32'sd1;

  localparam logic LAYOUT_POINTY = 1'b0;
  localparam logic LAYOUT_FLAT   = 1'b1;
  localparam logic ACT_TO_HEX    = 1'b0;
  localparam logic ACT_TO_PIXEL  = 1'b1;
  localparam logic CFG_CELL_SIZE = 1'b0;
  localparam logic CFG_LAYOUT    = 1'b1;

  localparam int CH_Q = 0;
  localparam int CH_R = 1;
  localparam int CH_S = 2;

  typedef struct packed {
    logic                  act;
    logic                  lay;
    logic [2:0]            neg;
    logic [DV_BITS-1:0]    dv;
    logic [COORD_BITS-1:0] px_x;
    logic [COORD_BITS-1:0] px_y;
  } side_t;

  typedef logic [2:0][NUM_BITS-1:0] num3_t;
  typedef logic [2:0][QUO_BITS-1:0] quo3_t;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [31:0] c;
    begin
      if (v > COORD_MAX) begin
        c = COORD_MAX;
      end else if (v < COORD_MIN) begin
        c = COORD_MIN;
      end else begin
        c = v;
      end
      return c[COORD_BITS-1:0];
    end
  endfunction

endpackage

[design/hgpc_front.sv]
module hgpc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic                            in_act,
  input  logic [hgpc_pkg::COORD_BITS-1:0] in_x,
  input  logic [hgpc_pkg::COORD_BITS-1:0] in_y,
  input  logic [hgpc_pkg::SIZE_BITS-1:0]  cell_size,
  input  logic                            layout,
  output logic                            out_valid,
  output hgpc_pkg::num3_t                 out_num,
  output hgpc_pkg::side_t                 out_side
);
  import hgpc_pkg::*;

  // Stage 0: input register.
  logic                         v0, act0, lay0;
  logic signed [COORD_BITS-1:0] x0, y0;
  logic [SIZE_BITS-1:0]         sz0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      act0 <= in_act;
      lay0 <= layout;
      x0   <= in_x;
      y0   <= in_y;
      sz0  <= (cell_size == '0) ? SIZE_BITS'(1) : cell_size;
    end
  end

  // Stage 1: products.
  logic signed [SQRT_BITS-1:0]  s3;
  logic signed [COORD_BITS-1:0] u;
  logic signed [33:0]           a;
  logic signed [NUM_BITS-1:0]   a_ext, x_sh, y_sh, x_sh2, y_sh2, nq, nr;
  logic signed [17:0]           t;
  logic [DV_BITS-1:0]           dv;
  logic [12:0]                  h;
  logic signed [30:0]           p;
  logic signed [29:0]           lin_p;
  logic signed [30:0]           lin_f;

  assign s3    = SQRT_BITS'(SQRT3_FIX);
  assign u     = (lay0 == LAYOUT_FLAT) ? y0 : x0;
  assign a     = s3 * u;
  assign a_ext = {a[33], a};
  assign x_sh  = $signed({{3{x0[15]}}, x0, 16'b0});
  assign y_sh  = $signed({{3{y0[15]}}, y0, 16'b0});
  assign x_sh2 = $signed({{2{x0[15]}}, x0, 17'b0});
  assign y_sh2 = $signed({{2{y0[15]}}, y0, 17'b0});
  assign nq    = (lay0 == LAYOUT_FLAT) ? x_sh2 : a_ext - y_sh;
  assign nr    = (lay0 == LAYOUT_FLAT) ? a_ext - x_sh : y_sh2;
  assign t     = (lay0 == LAYOUT_FLAT) ?
                 $signed({y0[15], y0, 1'b0}) + $signed({17'b0, x0[0]}) :
                 $signed({x0[15], x0, 1'b0}) - $signed({17'b0, y0[0]});
  assign dv    = ({2'b0, sz0} << 1) + {2'b0, sz0};
  assign h     = dv[13:1];
  assign p     = $signed({1'b0, sz0}) * t;
  assign lin_p = $signed({1'b0, h}) * y0;
  assign lin_f = $signed({1'b0, dv}) * x0;

  logic                       v1, act1, lay1;
  logic signed [NUM_BITS-1:0] nq1, nr1;
  logic signed [30:0]         p1, lin1;
  logic [DV_BITS-1:0]         dv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      act1 <= act0;
      lay1 <= lay0;
      nq1  <= nq;
      nr1  <= nr;
      p1   <= p;
      lin1 <= (lay0 == LAYOUT_FLAT) ? lin_f : {lin_p[29], lin_p};
      dv1  <= dv;
    end
  end

  // Stage 2: magnitudes and the sqrt(3) scaling.
  logic [NUM_BITS-1:0] ns, nq_n, nr_n, ns_n;
  logic [29:0]         pm;
  logic [16:0]         s3u;
  logic [46:0]         prod;
  logic signed [30:0]  lin_h;

  assign ns    = -nq1 - nr1;
  assign nq_n  = -nq1;
  assign nr_n  = -nr1;
  assign ns_n  = -ns;
  assign pm    = p1[30] ? 30'(-p1) : p1[29:0];
  assign s3u   = 17'(SQRT3_FIX);
  assign prod  = pm * s3u;
  // Halving of the flat-top column product truncates toward zero.
  assign lin_h = (lay1 == LAYOUT_FLAT) ? ($signed(lin1 + {30'b0, lin1[30]}) >>> 1) : lin1;

  logic                v2, act2, lay2, pneg2;
  logic [2:0]          neg2;
  logic [2:0][33:0]    mag2;
  logic [29:0]         sc2;
  logic signed [30:0]  lin2;
  logic [DV_BITS-1:0]  dv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      act2       <= act1;
      lay2       <= lay1;
      neg2[CH_Q] <= nq1[NUM_BITS-1];
      neg2[CH_R] <= nr1[NUM_BITS-1];
      neg2[CH_S] <= ns[NUM_BITS-1];
      mag2[CH_Q] <= nq1[NUM_BITS-1] ? nq_n[33:0] : nq1[33:0];
      mag2[CH_R] <= nr1[NUM_BITS-1] ? nr_n[33:0] : nr1[33:0];
      mag2[CH_S] <= ns[NUM_BITS-1] ? ns_n[33:0] : ns[33:0];
      sc2        <= prod[46:17];
      pneg2      <= p1[30];
      lin2       <= lin_h;
      dv2        <= dv1;
    end
  end

  // Stage 3: rounding bias for the divider and the finished pixel result.
  logic signed [31:0]    sc_s, lin_s;
  logic [COORD_BITS-1:0] sc_sat, lin_sat;
  num3_t                 nb;
  side_t                 sd;

  assign sc_s    = pneg2 ? -$signed({2'b0, sc2}) : $signed({2'b0, sc2});
  assign lin_s   = $signed({lin2[30], lin2});
  assign sc_sat  = sat_coord(sc_s);
  assign lin_sat = sat_coord(lin_s);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nb[c] = {mag2[c], 1'b0} + {5'b0, dv2, 16'b0};
    end
    sd.act  = act2;
    sd.lay  = lay2;
    sd.neg  = neg2;
    sd.dv   = dv2;
    sd.px_x = (lay2 == LAYOUT_FLAT) ? lin_sat : sc_sat;
    sd.px_y = (lay2 == LAYOUT_FLAT) ? sc_sat : lin_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_num  <= nb;
      out_side <= sd;
    end
  end

endmodule

[design/hgpc_div.sv]
module hgpc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  hgpc_pkg::num3_t in_num,
  input  hgpc_pkg::side_t in_side,
  output logic            out_valid,
  output hgpc_pkg::num3_t out_rem,
  output hgpc_pkg::quo3_t out_quo,
  output hgpc_pkg::side_t out_side
);
  import hgpc_pkg::*;

  logic  vld   [DIV_STAGES];
  num3_t rem_q [DIV_STAGES];
  quo3_t quo_q [DIV_STAGES];
  side_t side_q[DIV_STAGES];

  // One quotient bit per stage, most significant first, divisor 6*size*2^16.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic          vld_in;
    num3_t         rem_in, rem_nx;
    quo3_t         quo_in, quo_nx;
    side_t         side_in;
    logic [CMP_BITS-1:0] cand;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign cand = {{(CMP_BITS-DV_BITS){1'b0}}, side_in.dv} << (FRAC_BITS + 1 + DIV_STAGES - 1 - i);

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if ({{(CMP_BITS-NUM_BITS){1'b0}}, rem_in[c]} >= cand) begin
          rem_nx[c] = rem_in[c] - cand[NUM_BITS-1:0];
          quo_nx[c] = {quo_in[c][QUO_BITS-2:0], 1'b1};
        end else begin
          rem_nx[c] = rem_in[c];
          quo_nx[c] = {quo_in[c][QUO_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_in;
      end
      if (en) begin
        rem_q[i]  <= rem_nx;
        quo_q[i]  <= quo_nx;
        side_q[i] <= side_in;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_rem   = rem_q[DIV_STAGES-1];
  assign out_quo   = quo_q[DIV_STAGES-1];
  assign out_side  = side_q[DIV_STAGES-1];

  logic [NUM_BITS-1:0] dv2_full;
  assign dv2_full = {{(NUM_BITS-DV_BITS-FRAC_BITS-1){1'b0}}, out_side.dv, {(FRAC_BITS+1){1'b0}}};

  // The numerators are bounded so that the quotient's top bit stays clear.
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_quo[CH_Q][QUO_BITS-1] && !out_quo[CH_R][QUO_BITS-1]
                  && !out_quo[CH_S][QUO_BITS-1])
    else $error("quotient out of range");

  a_rem_q: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem[CH_Q] < dv2_full && out_rem[CH_R] < dv2_full)
    else $error("remainder not reduced");

  a_rem_s: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem[CH_S] < dv2_full)
    else $error("remainder not reduced");

endmodule

[design/hgpc_round.sv]
module hgpc_round (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  hgpc_pkg::num3_t                   in_rem,
  input  hgpc_pkg::quo3_t                   in_quo,
  input  hgpc_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic [2*hgpc_pkg::COORD_BITS-1:0] out_data
);
  import hgpc_pkg::*;

  // Stage R1: signed rounded values and twice the rounding errors, |D - R|.
  logic [REM_BITS-1:0]                d_full;
  logic [2:0][K_BITS-1:0]             k_nx;
  logic [2:0][ERR_BITS-1:0]           e_nx;
  logic signed [31:0]                 diff;

  assign d_full = {1'b0, in_side.dv, {FRAC_BITS{1'b0}}};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff    = $signed({1'b0, d_full}) - $signed({1'b0, in_rem[c][REM_BITS-1:0]});
      e_nx[c] = diff[31] ? ERR_BITS'(-diff) : diff[ERR_BITS-1:0];
      k_nx[c] = in_side.neg[c] ? -{1'b0, in_quo[c]} : {1'b0, in_quo[c]};
    end
  end

  logic                     v1;
  logic [2:0][K_BITS-1:0]   k1;
  logic [2:0][ERR_BITS-1:0] e1;
  side_t                    sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      k1  <= k_nx;
      e1  <= e_nx;
      sd1 <= in_side;
    end
  end

  // Stage R2: largest-error component is recomputed; ties favour r, then s.
  logic                       big_q, big_s;
  logic signed [AX_BITS-1:0]  kq, kr, ks, q_nx, r_nx;

  assign kq    = $signed({{2{k1[CH_Q][K_BITS-1]}}, k1[CH_Q]});
  assign kr    = $signed({{2{k1[CH_R][K_BITS-1]}}, k1[CH_R]});
  assign ks    = $signed({{2{k1[CH_S][K_BITS-1]}}, k1[CH_S]});
  assign big_q = (e1[CH_Q] > e1[CH_S]) && (e1[CH_Q] > e1[CH_R]);
  assign big_s = e1[CH_S] > e1[CH_R];
  assign q_nx  = big_q ? -ks - kr : kq;
  assign r_nx  = (!big_q && !big_s) ? -kq - ks : kr;

  logic                      v2;
  logic signed [AX_BITS-1:0] q2, r2;
  side_t                     sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      q2  <= q_nx;
      r2  <= r_nx;
      sd2 <= sd1;
    end
  end

  // Stage R3: axial to offset coordinates, saturation, output register.
  logic signed [OFS_BITS-1:0] qe, re, col, row;
  logic [COORD_BITS-1:0]      hx, hy;

  assign qe  = $signed({q2[AX_BITS-1], q2});
  assign re  = $signed({r2[AX_BITS-1], r2});
  assign col = (sd2.lay == LAYOUT_FLAT) ? qe :
               qe + ($signed(re + $signed({{(OFS_BITS-1){1'b0}}, re[0]})) >>> 1);
  assign row = (sd2.lay == LAYOUT_FLAT) ?
               re + ($signed(qe - $signed({{(OFS_BITS-1){1'b0}}, qe[0]})) >>> 1) : re;
  assign hx  = sat_coord($signed({{(32-OFS_BITS){col[OFS_BITS-1]}}, col}));
  assign hy  = sat_coord($signed({{(32-OFS_BITS){row[OFS_BITS-1]}}, row}));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_data <= (sd2.act == ACT_TO_PIXEL) ? {sd2.px_y, sd2.px_x} : {hy, hx};
    end
  end

endmodule

[design/hex_grid_pixel_convert_top.sv]
// Pipeline from the input transfer to result valid: 4 front stages,
// 16 restoring divider stages and 3 rounding stages, the same for both directions.
// Throughput: one item per cycle while not stalled; the divider sets the depth.
// A stalled output holds the whole pipeline in place.
// Reset clears all valid bits, cell_size to 32 and layout to pointy-top.
module hex_grid_pixel_convert_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [2*hgpc_pkg::COORD_BITS-1:0] s_tdata,   // coord_x, coord_y
  input  logic [0:0]                        s_tuser,   // action
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*hgpc_pkg::COORD_BITS-1:0] m_tdata,   // result_x, result_y
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [hgpc_pkg::SIZE_BITS-1:0]    cfg_data
);
  import hgpc_pkg::*;

  logic [SIZE_BITS-1:0] cell_size;
  logic                 layout;
  logic                 en;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= SIZE_BITS'(32);
      layout    <= LAYOUT_POINTY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CELL_SIZE: cell_size <= cfg_data;
        CFG_LAYOUT:    layout    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  logic  f_valid, d_valid;
  num3_t f_num, d_rem;
  quo3_t d_quo;
  side_t f_side, d_side;

  hgpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_act    (s_tuser[0]),
    .in_x      (s_tdata[COORD_BITS-1:0]),
    .in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cell_size (cell_size),
    .layout    (layout),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_side  (f_side)
  );

  hgpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_rem   (d_rem),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  hgpc_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_rem    (d_rem),
    .in_quo    (d_quo),
    .in_side   (d_side),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

[tb/hex_grid_pixel_convert_top_tb.sv]
`timescale 1ns / 100ps

module hex_grid_pixel_convert_top_tb;
  import hgpc_pkg::*;

  localparam int SQ3 = 113512;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic [11:0] cur_size;
  logic        cur_layout;

  logic [31:0] pending_coords[$];
  int          mismatches = 0;
  int          idle_pct = 35;
  int          hold_off = 0;
  bit          hold_start = 1'b0;
  bit          sink_idle = 1'b1;

  hex_grid_pixel_convert_top dut (.*);

  always #10 clk = ~clk;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_half_away(longint n, longint d, output longint err);
    longint m, k, kd;
    m = (n < 0) ? -n : n;
    k = (2 * m + d) / (2 * d);
    kd = k * d;
    err = (kd > m) ? kd - m : m - kd;
    return (n < 0) ? -k : k;
  endfunction

  function automatic longint sqrt3_trunc(longint p);
    longint m;
    m = (p < 0) ? -p : p;
    if (m > (64'sd1 << 33)) m = 64'sd1 << 33;
    m = (m * SQ3) >>> 17;
    return (p < 0) ? -m : m;
  endfunction

  function automatic logic [31:0] convert_coord(logic act, logic signed [15:0] cx,
                                                logic signed [15:0] cy);
    longint sz, x, y, rx, ry, nq, nr, ns, q, r, s, eq, er, es, d;
    logic [15:0] ox, oy;
    sz = (cur_size == 0) ? 1 : longint'(cur_size);
    x = cx;
    y = cy;
    if (act == ACT_TO_HEX) begin
      d = 3 * sz * 65536;
      if (cur_layout == LAYOUT_POINTY) begin
        nq = SQ3 * x - y * 65536;
        nr = 2 * y * 65536;
      end else begin
        nq = 2 * x * 65536;
        nr = SQ3 * y - x * 65536;
      end
      ns = -nq - nr;
      q = round_half_away(nq, d, eq);
      s = round_half_away(ns, d, es);
      r = round_half_away(nr, d, er);
      if (eq > es && eq > er) q = -s - r;
      else if (es > er) s = -q - r;
      else r = -q - s;
      if (cur_layout == LAYOUT_POINTY) begin
        rx = q + (r + (r & 1)) / 2;
        ry = r;
      end else begin
        rx = q;
        ry = r + (q - (q & 1)) / 2;
      end
    end else if (cur_layout == LAYOUT_POINTY) begin
      rx = sqrt3_trunc(sz * (2 * x - (y & 1)));
      ry = ((3 * sz) / 2) * y;
    end else begin
      rx = (sz * x * 3) / 2;
      ry = sqrt3_trunc(sz * (2 * y + (x & 1)));
    end
    ox = 16'(sat16(rx));
    oy = 16'(sat16(ry));
    return {oy, ox};
  endfunction

  task automatic send_coord(logic act, logic [15:0] cx, logic [15:0] cy);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cy, cx};
    s_tuser <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_coords.push_back(convert_coord(act, cx, cy));
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_coords.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [11:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CELL_SIZE) cur_size = val;
    else cur_layout = val[0];
  endtask

  task automatic test_directed();
    logic [15:0] edges[6] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0011};
    for (int l = 0; l < 2; l++) begin
      write_reg(CFG_LAYOUT, 12'(l));
      for (int i = 0; i < 6; i++)
        send_coord(i[0], edges[i], edges[5 - i]);
      send_coord(ACT_TO_HEX, 16'd24, 16'd24);   // exact half at size 32
      send_coord(ACT_TO_PIXEL, 16'h7FFF, 16'h8000);
    end
    write_reg(CFG_CELL_SIZE, 12'd0);             // zero size behaves as one
    send_coord(ACT_TO_HEX, 16'd5, 16'hFFFD);
    send_coord(ACT_TO_PIXEL, 16'd3, 16'd7);
  endtask

  task automatic test_random_settings();
    logic [11:0] sizes[5] = '{12'd1, 12'd4095, 12'd32, 12'd7, 12'd0};
    for (int k = 0; k < 5; k++) begin
      write_reg(CFG_CELL_SIZE, sizes[k]);
      write_reg(CFG_LAYOUT, 12'(k & 1));
      idle_pct = (k == 2) ? 0 : 35;
      sink_idle = (k != 2);
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(3) == 0)
          send_coord(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
        else
          send_coord(1'($urandom_range(1)), 16'($signed($urandom_range(400)) - 200),
                     16'($signed($urandom_range(400)) - 200));
      end
    end
    idle_pct = 35;
    sink_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 60; i++)
      send_coord(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
    drain_results();
  endtask

  // Hold-off window length, counted in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (hold_start) begin
      hold_off <= 300;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Sink: random stalls, an always-ready stretch, and an explicit hold-off window.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= sink_idle ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", m_tdata);
      end else begin
        want = pending_coords.pop_front();
        if (want[15:0] !== m_tdata[15:0] || want[31:16] !== m_tdata[31:16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected x=%h y=%h got x=%h y=%h",
                     want[15:0], want[31:16], m_tdata[15:0], m_tdata[31:16]);
        end
      end
    end
  end

  initial begin
    cur_size = 12'd32;
    cur_layout = LAYOUT_POINTY;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    drain_results();
    if (mismatches == 0 && pending_coords.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
design/hgpc_pkg.sv
design/hgpc_front.sv
design/hgpc_div.sv
design/hgpc_round.sv
design/hex_grid_pixel_convert_top.sv
tb/hex_grid_pixel_convert_top_tb.sv
